>>> design/rcq_pkg.sv
// rcq_pkg: shared types, codes and helpers for the range count query engine
// no dependencies; used by rcq_ctrl, rcq_dp and range_count_query_engine
package rcq_pkg;

  localparam int unsigned VAL_W  = 10;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned KIND_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

  // controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic clr_en;     // write zero at the walk index, advance
    logic ld_rd;      // read entry of the incoming point value
    logic ld_wr;      // write back incremented count
    logic bld_start;  // start running-total walk, read entry zero
    logic bld_step;   // accumulate, write back, read next entry
    logic q_hi;       // capture query bounds, read upper entry
    logic q_lo;       // keep upper total, read entry below lower bound
    logic q_res;      // form the answer into the output register
  } rcq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;   // walk index is at the last table entry
    logic ld_ok;      // incoming load would be counted
    logic built;      // running totals have been built
    logic out_free;   // output register can take a result this cycle
  } rcq_stat_t;

  // saturating 16-bit add
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

>>> design/rcq_ctrl.sv
// rcq_ctrl: sequencing state machine of the range count query engine
// depends on rcq_pkg; drives rcq_dp through rcq_cmd_t, reads rcq_stat_t
module rcq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rcq_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  input  rcq_pkg::rcq_stat_t          stat,
  output rcq_pkg::rcq_cmd_t           cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LDW  = 3'd2;
  localparam logic [2:0] S_BLD  = 3'd3;
  localparam logic [2:0] S_QLO  = 3'd4;
  localparam logic [2:0] S_QRES = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (stat.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            rcq_pkg::KIND_LOAD: begin
              if (stat.ld_ok) begin
                cmd.ld_rd = 1'b1;
                state_nxt = S_LDW;
              end
            end
            rcq_pkg::KIND_BUILD: begin
              if (!stat.built) begin
                cmd.bld_start = 1'b1;
                state_nxt     = S_BLD;
              end
            end
            rcq_pkg::KIND_QUERY: begin
              cmd.q_hi  = 1'b1;
              state_nxt = S_QLO;
            end
            default: ;
          endcase
        end
      end
      S_LDW: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_BLD: begin
        cmd.bld_step = 1'b1;
        if (stat.idx_last) state_nxt = S_IDLE;
      end
      S_QLO: begin
        cmd.q_lo  = 1'b1;
        state_nxt = S_QRES;
      end
      S_QRES: begin
        if (stat.out_free) begin
          cmd.q_res = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // state register, clearing pass runs first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/rcq_dp.sv
// rcq_dp: count table memory, walk index, accumulator, query math and output register
// depends on rcq_pkg; commanded by rcq_ctrl
module rcq_dp #(
  parameter int unsigned VALUE_RANGE = 1024,
  parameter int unsigned MAX_POINTS  = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rcq_pkg::VAL_W-1:0]   in_point_value,
  input  logic [rcq_pkg::VAL_W-1:0]   in_range_low,
  input  logic [rcq_pkg::VAL_W-1:0]   in_range_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcq_pkg::CNT_W-1:0]   out_point_count,
  output logic                        out_not_built,
  input  rcq_pkg::rcq_cmd_t           cmd,
  output rcq_pkg::rcq_stat_t          stat
);

  localparam int unsigned AW  = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int unsigned VW  = (AW > rcq_pkg::VAL_W) ? AW : rcq_pkg::VAL_W;
  localparam int unsigned LTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW  = rcq_pkg::CNT_W;
  localparam int unsigned PW  = rcq_pkg::VAL_W;

  localparam logic [VW-1:0]  TOP_VAL = VW'(VALUE_RANGE - 1);
  localparam logic [AW-1:0]  TOP_IDX = AW'(VALUE_RANGE - 1);
  localparam logic [LTW-1:0] MAX_LD  = LTW'(MAX_POINTS);

  logic [CW-1:0]  mem [VALUE_RANGE];
  logic [CW-1:0]  rdata_r;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [CW-1:0]  wr_data;

  logic [AW-1:0]  idx_r;
  logic [CW-1:0]  acc_r;
  logic [CW-1:0]  acc_nxt;
  logic           built_r;
  logic [LTW-1:0] loaded_r;
  logic [PW-1:0]  lo_r;
  logic           lo_zero_r;
  logic           lo_le_hi_r;
  logic [CW-1:0]  top_r;
  logic           out_valid_r;
  logic [CW-1:0]  out_cnt_r;
  logic           out_nb_r;

  logic [VW-1:0]  hi_clip;
  logic [PW-1:0]  lo_m1;
  logic [CW-1:0]  bot;
  logic [CW-1:0]  cnt;

  // query bound handling
  always_comb begin
    hi_clip = (VW'(in_range_high) > TOP_VAL) ? TOP_VAL : VW'(in_range_high);
    lo_m1   = lo_r - PW'(1);
    bot     = lo_zero_r ? '0 : rdata_r;
    cnt     = '0;
    if (built_r && lo_le_hi_r && (top_r >= bot)) cnt = top_r - bot;
  end

  assign acc_nxt = rcq_pkg::sat_add(acc_r, rdata_r);

  // status to controller
  always_comb begin
    stat.idx_last = (idx_r == TOP_IDX);
    stat.ld_ok    = !built_r && (loaded_r < MAX_LD) && (VW'(in_point_value) <= TOP_VAL);
    stat.built    = built_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = '0;
    priority if (cmd.ld_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(in_point_value);
    end else if (cmd.bld_start) begin
      rd_en   = 1'b1;
    end else if (cmd.bld_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_r + AW'(1);
      wr_en   = 1'b1;
      wr_data = acc_nxt;
    end else if (cmd.q_hi) begin
      rd_en   = 1'b1;
      rd_addr = hi_clip[AW-1:0];
    end else if (cmd.q_lo) begin
      rd_en   = 1'b1;
      rd_addr = AW'(lo_m1);
    end else if (cmd.clr_en) begin
      wr_en   = 1'b1;
    end else if (cmd.ld_wr) begin
      wr_en   = 1'b1;
      wr_data = rcq_pkg::sat_add(rdata_r, CW'(1));
    end else begin
      rd_en   = 1'b0;
    end
  end

  // count table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      built_r     <= 1'b0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en || cmd.bld_step) idx_r <= idx_r + AW'(1);
      else if (cmd.bld_start)         idx_r <= '0;
      else if (cmd.ld_rd)             idx_r <= AW'(in_point_value);
      if (cmd.bld_step && stat.idx_last) built_r <= 1'b1;
      if (cmd.ld_wr) loaded_r <= loaded_r + LTW'(1);
      if (cmd.q_res)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.bld_start) acc_r <= '0;
    else if (cmd.bld_step) acc_r <= acc_nxt;
    if (cmd.q_hi) begin
      lo_r       <= in_range_low;
      lo_zero_r  <= (in_range_low == '0);
      lo_le_hi_r <= (VW'(in_range_low) <= hi_clip);
    end
    if (cmd.q_lo) top_r <= rdata_r;
    if (cmd.q_res) begin
      out_cnt_r <= cnt;
      out_nb_r  <= !built_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_count = out_cnt_r;
  assign out_not_built   = out_nb_r;

endmodule

>>> design/range_count_query_engine.sv
// range_count_query_engine: top level, prefix-sum range count over a point histogram
// depends on rcq_pkg, rcq_ctrl and rcq_dp
//
//  channel | ports                                              | direction
//  in      | in_valid in_ready in_kind in_point_value           | request in
//          | in_range_low in_range_high                         |
//  out     | out_valid out_ready out_point_count out_not_built  | result out
//
// a load is a read-modify-write and a query makes two reads, both on the
// single read port of the count table; a build walks every table entry in order.
// after reset a clearing pass zeroes every table entry, with in_ready low.
// a finished query waits in its result state until the output register is free;
// loads and builds proceed while a result waits on out_ready.
module range_count_query_engine #(
  parameter int unsigned VALUE_RANGE = 1024,
  parameter int unsigned MAX_POINTS  = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rcq_pkg::KIND_W-1:0]  in_kind,
  input  logic [rcq_pkg::VAL_W-1:0]   in_point_value,
  input  logic [rcq_pkg::VAL_W-1:0]   in_range_low,
  input  logic [rcq_pkg::VAL_W-1:0]   in_range_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcq_pkg::CNT_W-1:0]   out_point_count,
  output logic                        out_not_built
);

  rcq_pkg::rcq_cmd_t  cmd;
  rcq_pkg::rcq_stat_t stat;

  // sequencer
  rcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and arithmetic
  rcq_dp #(
    .VALUE_RANGE (VALUE_RANGE),
    .MAX_POINTS  (MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_point_value  (in_point_value),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_count (out_point_count),
    .out_not_built   (out_not_built),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
